@@ rtl/amp_sfp_pkg.sv @@
// Package for the amplifier status frame parser: header codes, sub-command
// codes, report kinds and the fixed-frame decode function.
// Depends on nothing; used by amp_status_frame_parser.
package amp_sfp_pkg;

	localparam logic [7:0] HDR_SWITCH_REP = 8'hB9;
	localparam logic [7:0] HDR_PLAY_REP   = 8'hE9;
	localparam logic [7:0] HDR_SONG       = 8'hF1;
	localparam logic [7:0] HDR_VAR_F2     = 8'hF2;
	localparam logic [7:0] HDR_VAR_FC     = 8'hFC;

	// fixed 5-byte headers that carry nothing we report
	localparam logic [7:0] HDR_SKIP_BD    = 8'hBD;
	localparam logic [7:0] HDR_SKIP_D4    = 8'hD4;
	localparam logic [7:0] HDR_SKIP_D8    = 8'hD8;
	localparam logic [7:0] HDR_SKIP_D5    = 8'hD5;
	localparam logic [7:0] HDR_SKIP_D6    = 8'hD6;
	localparam logic [7:0] HDR_SKIP_B0    = 8'hB0;
	localparam logic [7:0] HDR_SKIP_D7    = 8'hD7;
	localparam logic [7:0] HDR_SKIP_DE    = 8'hDE;
	localparam logic [7:0] HDR_SKIP_A1    = 8'hA1;

	localparam logic [7:0] FIXED_LEN      = 8'd5;
	localparam logic [7:0] ZERO_LEN_SKIP  = 8'd6;
	localparam logic [7:0] SONG_MIN_LEN   = 8'd5;
	localparam logic [7:0] SONG_NAME_LEN  = 8'd6;
	localparam logic [7:0] NAME_FIRST_POS = 8'd4;
	localparam logic [7:0] NAME_CUT_POS   = 8'd5;

	localparam logic [7:0] LEN_REPLAY     = 8'd1;
	localparam logic [7:0] LEN_RESYNC     = 8'd2;

	localparam logic [7:0] SUB_POWER_ON   = 8'h03;
	localparam logic [7:0] SUB_POWER_OFF  = 8'h04;
	localparam logic [7:0] SUB_SOURCE     = 8'h05;
	localparam logic [7:0] SUB_VOLUME     = 8'h07;
	localparam logic [7:0] SUB_EQ         = 8'h0a;
	localparam logic [7:0] SUB_PLAY       = 8'h02;
	localparam logic [7:0] SUB_MUTE       = 8'h04;

	localparam logic [7:0] VAL_FLAG       = 8'h80;
	localparam logic [7:0] VAL_LOW_MASK   = 8'h7F;
	localparam logic [7:0] VOL_MASK       = 8'h1F;
	localparam logic [7:0] SOURCE_MAX     = 8'd3;
	localparam logic [7:0] VOLUME_MAX     = 8'd31;
	localparam logic [7:0] EQ_MAX         = 8'd5;
	localparam logic [7:0] BINARY_MAX     = 8'd1;

	typedef enum logic [2:0] {
		KIND_SWITCH,
		KIND_SOURCE,
		KIND_VOLUME,
		KIND_EQ,
		KIND_PLAY,
		KIND_MUTE,
		KIND_NAME_BYTE,
		KIND_NAME_END
	} report_kind_t;

	typedef struct packed {
		logic         hit;
		report_kind_t kind;
		logic [7:0]   value;
	} decode_t;

	function automatic logic is_fixed_hdr(input logic [7:0] h);
		return h inside {HDR_SWITCH_REP, HDR_PLAY_REP, HDR_SKIP_BD, HDR_SKIP_D4,
			HDR_SKIP_D8, HDR_SKIP_D5, HDR_SKIP_D6, HDR_SKIP_B0, HDR_SKIP_D7,
			HDR_SKIP_DE, HDR_SKIP_A1};
	endfunction

	function automatic logic is_var_hdr(input logic [7:0] h);
		return h inside {HDR_SONG, HDR_VAR_F2, HDR_VAR_FC};
	endfunction

	// Decode a checked 5-byte report frame from its sub-command and value bytes.
	function automatic decode_t decode_fixed(input logic [7:0] hdr, input logic [7:0] sub,
		input logic [7:0] val);
		decode_t    d;
		logic [7:0] low;
		logic       top;
		low     = val & VAL_LOW_MASK;
		top     = (val & VAL_FLAG) == VAL_FLAG;
		d.hit   = 1'b0;
		d.kind  = KIND_SWITCH;
		d.value = '0;
		if (hdr == HDR_SWITCH_REP) begin
			if (sub == SUB_POWER_ON && val == VAL_FLAG) begin
				d.hit = 1'b1; d.kind = KIND_SWITCH; d.value = 8'd0;
			end else if (sub == SUB_POWER_OFF && val == VAL_FLAG) begin
				d.hit = 1'b1; d.kind = KIND_SWITCH; d.value = 8'd1;
			end else if (sub == SUB_SOURCE && top && low <= SOURCE_MAX) begin
				d.hit = 1'b1; d.kind = KIND_SOURCE; d.value = low;
			end else if (sub == SUB_VOLUME && top && low <= VOLUME_MAX) begin
				d.hit = 1'b1; d.kind = KIND_VOLUME; d.value = val & VOL_MASK;
			end else if (sub == SUB_EQ && top && low <= EQ_MAX) begin
				d.hit = 1'b1; d.kind = KIND_EQ; d.value = low;
			end
		end else if (hdr == HDR_PLAY_REP && val <= BINARY_MAX) begin
			if (sub == SUB_PLAY) begin
				d.hit = 1'b1; d.kind = KIND_PLAY; d.value = val;
			end else if (sub == SUB_MUTE) begin
				d.hit = 1'b1; d.kind = KIND_MUTE; d.value = val;
			end
		end
		return d;
	endfunction

endpackage

@@ rtl/amp_status_frame_parser.sv @@
// Byte-serial parser for an amplifier's reply stream: frame tracking,
// check XOR, report decode and song-name streaming.
// Depends on amp_sfp_pkg.
//
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------
// rx       | rx_valid/rx_stall  | rx_byte, port_id, end_of_buffer
// report   | report_valid/_stall| report_kind, report_value, check_ok,
//          |                    | report_port
//
// One byte is taken every cycle while rx_stall is low; a report passes the input
// register and is then held in the report register. The frame state loop (position,
// header, length, XOR) closes combinationally between the input register and the report register.
// rx_stall rises only when a byte waits in the input register while a report
// is held by report_stall. Reset clears the frame state to header hunting.
module amp_status_frame_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	input  logic [7:0] port_id,
	input  logic       end_of_buffer,
	output logic       report_valid,
	input  logic       report_stall,
	output logic [2:0] report_kind,
	output logic [7:0] report_value,
	output logic       check_ok,
	output logic [7:0] report_port
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [7:0] port_s1;
	logic       eob_s1;

	// frame state
	logic [7:0] pos_q, pos_n;
	logic [7:0] hdr_q, hdr_n;
	logic [7:0] fb0_q, fb0_n;
	logic [7:0] fb1_q, fb1_n;
	logic [7:0] xor_q, xor_n;
	logic [7:0] len_q, len_n;

	// result register
	logic                      res_valid_q;
	amp_sfp_pkg::report_kind_t res_kind_q;
	logic [7:0]                res_value_q;
	logic                      res_ok_q;
	logic [7:0]                res_port_q;

	logic                      hit;
	amp_sfp_pkg::report_kind_t kind;
	logic [7:0]                value;
	logic                      ok;
	logic                      adv;
	logic [7:0]                eff;
	logic                      cont;
	amp_sfp_pkg::decode_t      dec;

	assign adv      = valid_s1 && (!res_valid_q || !report_stall);
	assign rx_stall = valid_s1 && !adv;
	assign dec      = amp_sfp_pkg::decode_fixed(hdr_q, fb0_q, fb1_q);

	always_comb begin
		pos_n = pos_q;
		hdr_n = hdr_q;
		fb0_n = fb0_q;
		fb1_n = fb1_q;
		xor_n = xor_q;
		len_n = len_q;
		hit   = 1'b0;
		kind  = amp_sfp_pkg::KIND_SWITCH;
		value = '0;
		ok    = 1'b0;
		eff   = len_q;
		cont  = 1'b0;
		if (pos_q == 8'd0) begin
			// hunt: unknown bytes drop alone
			if (amp_sfp_pkg::is_fixed_hdr(byte_s1) || amp_sfp_pkg::is_var_hdr(byte_s1)) begin
				hdr_n = byte_s1;
				len_n = amp_sfp_pkg::is_fixed_hdr(byte_s1) ? amp_sfp_pkg::FIXED_LEN : 8'd0;
				xor_n = '0;
				pos_n = 8'd1;
			end
		end else if (amp_sfp_pkg::is_var_hdr(hdr_q) && pos_q == 8'd2 &&
			(byte_s1 == amp_sfp_pkg::LEN_REPLAY || byte_s1 == amp_sfp_pkg::LEN_RESYNC)) begin
			// length too short: on LEN_REPLAY rescan the byte after the header, then this one; else hunt
			pos_n = 8'd0;
			if (byte_s1 == amp_sfp_pkg::LEN_REPLAY &&
				(amp_sfp_pkg::is_fixed_hdr(fb0_q) || amp_sfp_pkg::is_var_hdr(fb0_q))) begin
				hdr_n = fb0_q;
				len_n = amp_sfp_pkg::is_fixed_hdr(fb0_q) ? amp_sfp_pkg::FIXED_LEN : 8'd0;
				xor_n = byte_s1;
				fb0_n = byte_s1;
				pos_n = 8'd2;
			end
		end else begin
			if (amp_sfp_pkg::is_var_hdr(hdr_q) && pos_q == 8'd2) begin
				len_n = byte_s1;
			end
			eff = (pos_q >= 8'd2 && len_n == 8'd0) ? amp_sfp_pkg::ZERO_LEN_SKIP : len_n;
			if (pos_q == 8'd1 || pos_q == 8'd2) begin
				fb0_n = byte_s1;
			end
			if (pos_q == 8'd3) begin
				fb1_n = byte_s1;
			end
			cont = pos_q < 8'd2 || ({1'b0, pos_q} + 9'd1) < {1'b0, eff};
			if (cont) begin
				xor_n = xor_q ^ byte_s1;
				pos_n = pos_q + 8'd1;
				if (hdr_q == amp_sfp_pkg::HDR_SONG && len_n >= amp_sfp_pkg::SONG_NAME_LEN &&
					pos_q >= amp_sfp_pkg::NAME_FIRST_POS) begin
					hit   = 1'b1;
					kind  = amp_sfp_pkg::KIND_NAME_BYTE;
					value = byte_s1;
				end
			end else begin
				pos_n = 8'd0;
				if (hdr_q == amp_sfp_pkg::HDR_SWITCH_REP || hdr_q == amp_sfp_pkg::HDR_PLAY_REP) begin
					if (xor_q == byte_s1) begin
						hit   = dec.hit;
						kind  = dec.kind;
						value = dec.value;
					end
				end else if (hdr_q == amp_sfp_pkg::HDR_SONG &&
					len_n >= amp_sfp_pkg::SONG_MIN_LEN) begin
					hit  = 1'b1;
					kind = amp_sfp_pkg::KIND_NAME_END;
					ok   = xor_q == byte_s1;
				end
			end
		end
		// end of buffer: drop a cut frame, close a started name
		if (eob_s1 && pos_n != 8'd0) begin
			if (hdr_n == amp_sfp_pkg::HDR_SONG && len_n >= amp_sfp_pkg::SONG_NAME_LEN &&
				pos_n >= amp_sfp_pkg::NAME_CUT_POS) begin
				hit   = 1'b1;
				kind  = amp_sfp_pkg::KIND_NAME_END;
				value = '0;
				ok    = 1'b0;
			end
			pos_n = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall) begin
			byte_s1 <= rx_byte;
			port_s1 <= port_id;
			eob_s1  <= end_of_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_q <= '0;
			fb0_q <= '0;
			fb1_q <= '0;
			xor_q <= '0;
			len_q <= '0;
		end else if (adv) begin
			pos_q <= pos_n;
			hdr_q <= hdr_n;
			fb0_q <= fb0_n;
			fb1_q <= fb1_n;
			xor_q <= xor_n;
			len_q <= len_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && hit) begin
			res_valid_q <= 1'b1;
		end else if (!report_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && hit) begin
			res_kind_q  <= kind;
			res_value_q <= value;
			res_ok_q    <= ok;
			res_port_q  <= port_s1;
		end
	end

	assign report_valid = res_valid_q;
	assign report_kind  = res_kind_q;
	assign report_value = res_value_q;
	assign check_ok     = res_ok_q;
	assign report_port  = res_port_q;

`ifndef SYNTHESIS
	a_eob_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eob_s1 |=> pos_q == 8'd0)
		else $error("frame position not cleared after end of buffer");

	a_ok_only_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && check_ok |-> res_kind_q == amp_sfp_pkg::KIND_NAME_END)
		else $error("check_ok set on a report other than name end");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && res_kind_q == amp_sfp_pkg::KIND_VOLUME |->
			res_value_q <= amp_sfp_pkg::VOLUME_MAX)
		else $error("volume report out of range");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1 && res_valid_q && report_stall)
		else $error("rx stalled without a blocked report");
`endif

endmodule
